### rtl/u8d_pkg.sv
package u8d_pkg;

  localparam logic [7:0]  ASCII_LIMIT = 8'h80;
  localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
  localparam logic [7:0]  LEAD4_CODE  = 8'hF0;
  localparam logic [20:0] QMARK       = 21'd63;
  localparam int          HELD_MAX    = 3;

  typedef logic [HELD_MAX-1:0][7:0] held_t;

  typedef struct packed {
    logic        flush;
    logic [1:0]  len;
    held_t       bytes;
    logic [20:0] cp;
  } job_t;

  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  adv;
  } dec_t;

  function automatic logic [1:0] lead_extra(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & LEAD2_MASK) == LEAD2_CODE) n = 2'd1;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) n = 2'd2;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) n = 2'd3;
    return n;
  endfunction

  function automatic logic [20:0] combine(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2, input logic [7:0] b3,
                                          input logic [1:0] n);
    logic [20:0] v;
    unique case (n)
      2'd1:    v = {10'd0, b0[4:0], b1[5:0]};
      2'd2:    v = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      2'd3:    v = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: v = {13'd0, b0};
    endcase
    return v;
  endfunction

  function automatic logic [7:0] byte_at(input held_t bytes, input logic [1:0] len,
                                         input logic [2:0] p);
    logic [7:0] b;
    b = 8'd0;
    if (p < {1'b0, len}) begin
      unique case (p)
        3'd0:    b = bytes[0];
        3'd1:    b = bytes[1];
        3'd2:    b = bytes[2];
        default: b = 8'd0;
      endcase
    end
    return b;
  endfunction

  function automatic dec_t decode_at(input held_t bytes, input logic [1:0] len,
                                     input logic [2:0] pos);
    dec_t       d;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [1:0] n;
    logic       short;
    b0 = byte_at(bytes, len, pos);
    b1 = byte_at(bytes, len, pos + 3'd1);
    b2 = byte_at(bytes, len, pos + 3'd2);
    b3 = byte_at(bytes, len, pos + 3'd3);
    n = lead_extra(b0);
    short = (b1 == 8'd0) || ((n > 2'd1) && (b2 == 8'd0)) || ((n == 2'd3) && (b3 == 8'd0));
    if (b0 < ASCII_LIMIT) begin
      d.cp  = {13'd0, b0};
      d.adv = 3'd1;
    end else if (n == 2'd0 || short) begin
      d.cp  = QMARK;
      d.adv = 3'd1;
    end else begin
      d.cp  = combine(b0, b1, b2, b3, n);
      d.adv = {1'b0, n} + 3'd1;
    end
    return d;
  endfunction

endpackage

### rtl/utf8_stream_decoder.sv
// channel | ports                                | direction
// in      | in_valid, in_ready, in_text_byte      | byte request in
// out     | out_valid, out_ready, out_code_point, | result request out
//         | out_end_of_text                       |
// One byte per cycle while the job queue has room; out_valid is registered behind the queue.
// A terminating zero turns into one queue entry that the back end expands into up to four
// results, one per cycle while out_ready allows, through the single output register.
// Reset (rst_n low, synchronous) clears held byte count, queue pointers and out_valid.
// A stall on out_ready fills the queue; in_ready drops only when it is full.
module utf8_stream_decoder import u8d_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_end_of_text
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  u8d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  u8d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  u8d_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_job           (q_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_end_of_text (out_end_of_text)
  );

endmodule

### rtl/u8d_front.sv
module u8d_front import u8d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [1:0] cnt_r, cnt_nxt;
  held_t      held_r, held_nxt;
  logic       acc;
  logic [1:0] n;
  logic [7:0] f1;
  logic [7:0] f2;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign n        = lead_extra(held_r[0]);
  assign f1       = (cnt_r > 2'd1) ? held_r[1] : in_text_byte;
  assign f2       = (cnt_r > 2'd2) ? held_r[2] : in_text_byte;

  always_comb begin
    cnt_nxt        = cnt_r;
    held_nxt       = held_r;
    push           = 1'b0;
    push_job.flush = 1'b0;
    push_job.len   = cnt_r;
    push_job.bytes = held_r;
    push_job.cp    = {13'd0, in_text_byte};
    if (acc) begin
      priority if (in_text_byte == 8'd0) begin
        push           = 1'b1;
        push_job.flush = 1'b1;
        cnt_nxt        = 2'd0;
      end else if (cnt_r == 2'd0) begin
        if (in_text_byte < ASCII_LIMIT) begin
          push = 1'b1;
        end else if (lead_extra(in_text_byte) == 2'd0) begin
          push        = 1'b1;
          push_job.cp = QMARK;
        end else begin
          held_nxt[0] = in_text_byte;
          cnt_nxt     = 2'd1;
        end
      end else if (cnt_r >= n) begin
        push        = 1'b1;
        push_job.cp = combine(held_r[0], f1, f2, in_text_byte, n);
        cnt_nxt     = 2'd0;
      end else begin
        held_nxt[cnt_r] = in_text_byte;
        cnt_nxt         = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    held_r <= held_nxt;
  end

endmodule

### rtl/u8d_queue.sv
module u8d_queue import u8d_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output job_t q_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_r];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

### rtl/u8d_back.sv
module u8d_back import u8d_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_end_of_text
);

  logic [1:0]  pos_r, pos_nxt;
  logic        out_valid_r;
  logic [20:0] cp_r;
  logic        eot_r;
  logic        fire;
  dec_t        dec;
  logic [2:0]  pos_sum;
  logic [20:0] res_cp;
  logic        res_eot;

  assign fire    = q_valid && (!out_valid_r || out_ready);
  assign dec     = decode_at(q_job.bytes, q_job.len, {1'b0, pos_r});
  assign pos_sum = {1'b0, pos_r} + dec.adv;

  always_comb begin
    pop     = 1'b0;
    pos_nxt = pos_r;
    res_cp  = q_job.cp;
    res_eot = 1'b0;
    priority if (!q_job.flush) begin
      pop = fire;
    end else if (pos_r < q_job.len) begin
      res_cp = dec.cp;
      if (fire) pos_nxt = pos_sum[1:0];
    end else begin
      res_cp  = 21'd0;
      res_eot = 1'b1;
      pop     = fire;
      if (fire) pos_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (fire) begin
      cp_r  <= res_cp;
      eot_r <= res_eot;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_end_of_text = eot_r;

endmodule

### rtl/u8d_checker.sv
module u8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_text_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] out_code_point,
  input logic        out_end_of_text
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point)
                                && $stable(out_end_of_text))
    else $error("result request changed while stalled");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_text |-> out_code_point == 21'd0)
    else $error("end marker carries a nonzero code point");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_text_byte))
    else $error("byte request changed while stalled");

endmodule

bind utf8_stream_decoder u8d_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_text_byte    (in_text_byte),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_code_point  (out_code_point),
  .out_end_of_text (out_end_of_text)
);

### test/tb_top.sv
module tb_top;
  import u8d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [20:0] cp;
    logic        eot;
  } point_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_text_byte    = 8'd0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [20:0] out_code_point;
  logic        out_end_of_text;

  point_t      expected_points[$];
  logic [7:0]  held_bytes[3];
  int          held_count      = 0;
  int          mismatch_count  = 0;
  int          send_idle_pct   = 38;
  int          recv_idle_pct   = 88;
  int          cycle_count     = 0;

  utf8_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_end_of_text(out_end_of_text)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int follow_count(input logic [7:0] b);
    if ((b & LEAD2_MASK) == LEAD2_CODE) return 1;
    if ((b & LEAD3_MASK) == LEAD3_CODE) return 2;
    if ((b & LEAD4_MASK) == LEAD4_CODE) return 3;
    return 0;
  endfunction

  function automatic logic [20:0] join_sequence(input logic [3:0][7:0] s, input int n);
    logic [20:0] v;
    case (n)
      1:       v = 21'(s[0] & 8'h1F);
      2:       v = 21'(s[0] & 8'h0F);
      default: v = 21'(s[0] & 8'h07);
    endcase
    for (int i = 1; i <= n; i++) v = (v << 6) | 21'(s[i] & 8'h3F);
    return v;
  endfunction

  function automatic int decode_held(input int pos, input int len, output logic [20:0] cp);
    logic [3:0][7:0] s;
    int              n;
    for (int i = 0; i < 4; i++) begin
      s[i] = 8'd0;
      if (pos + i < len) s[i] = held_bytes[pos + i];
    end
    if (s[0] < ASCII_LIMIT) begin
      cp = 21'(s[0]);
      return 1;
    end
    n = follow_count(s[0]);
    if (n == 0) begin
      cp = QMARK;
      return 1;
    end
    for (int i = 1; i <= n; i++) begin
      if (s[i] == 8'd0) begin
        cp = QMARK;
        return 1;
      end
    end
    cp = join_sequence(s, n);
    return n + 1;
  endfunction

  function automatic void push_point(input logic [20:0] cp, input logic eot);
    point_t p;
    p.cp  = cp;
    p.eot = eot;
    expected_points.push_back(p);
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [3:0][7:0] seq;
    logic [20:0]     cp;
    int              need;
    int              pos;
    int              len;
    int              k;
    if (held_count == 0) begin
      if (b == 8'd0) push_point(21'd0, 1'b1);
      else if (b < ASCII_LIMIT) push_point(21'(b), 1'b0);
      else if (follow_count(b) == 0) push_point(QMARK, 1'b0);
      else begin
        held_bytes[0] = b;
        held_count = 1;
      end
    end else if (b != 8'd0) begin
      need = follow_count(held_bytes[0]) + 1;
      if (held_count < 3) held_bytes[held_count] = b;
      held_count++;
      if (held_count >= need) begin
        for (int i = 0; i < 3; i++) seq[i] = (i < held_count) ? held_bytes[i] : 8'd0;
        seq[3] = 8'd0;
        seq[need - 1] = b;
        push_point(join_sequence(seq, need - 1), 1'b0);
        held_count = 0;
      end
    end else begin
      len = held_count;
      pos = 0;
      k = 0;
      while (pos < len && k < 3) begin
        pos += decode_held(pos, len, cp);
        push_point(cp, 1'b0);
        k++;
      end
      push_point(21'd0, 1'b1);
      held_count = 0;
    end
  endtask

  always @(posedge clk) begin : check_results
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual code_point=%0h end_of_text=%0b",
                 $time, out_code_point, out_end_of_text);
      end else begin
        want = expected_points.pop_front();
        if (out_code_point !== want.cp) begin
          mismatch_count++;
          $display("%0t: code_point mismatch, expected %0h, actual %0h",
                   $time, want.cp, out_code_point);
        end
        if (out_end_of_text !== want.eot) begin
          mismatch_count++;
          $display("%0t: end_of_text mismatch, expected %0b, actual %0b",
                   $time, want.eot, out_end_of_text);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    decode_byte(b);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [7:0] random_lead(input int n);
    logic [7:0] r;
    r = 8'($urandom);
    case (n)
      1:       return LEAD2_CODE | (r & ~LEAD2_MASK);
      2:       return LEAD3_CODE | (r & ~LEAD3_MASK);
      default: return LEAD4_CODE | (r & ~LEAD4_MASK);
    endcase
  endfunction

  function automatic logic [7:0] random_follow();
    if ($urandom_range(7) == 0) return 8'($urandom_range(1, 255));
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  task automatic test_plain_bytes();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_invalid_leads();
    send_byte(8'h80);
    send_byte(8'hBF);
    send_byte(8'hF8);
    send_byte(8'hFF);
  endtask

  task automatic test_full_sequences();
    send_byte(8'hC2); send_byte(8'h80);
    send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
    send_byte(8'hF7); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
    // continuation bits are ignored
    send_byte(8'hDF); send_byte(8'h41);
  endtask

  task automatic test_truncated_flush();
    send_byte(8'hF0); send_byte(8'h41); send_byte(8'hFE); send_byte(8'h00);
    // inner lead completes from the held bytes after it
    send_byte(8'hF0); send_byte(8'hC3); send_byte(8'h81); send_byte(8'h00);
  endtask

  task automatic test_random_text(input int byte_goal);
    int sent;
    int pick;
    int n;
    int keep;
    sent = 0;
    while (sent < byte_goal) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_byte(8'($urandom_range(1, 127)));
        sent++;
      end else if (pick < 25) begin
        if ($urandom_range(1)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
        else send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        sent++;
      end else if (pick < 75) begin
        n = $urandom_range(1, 3);
        send_byte(random_lead(n));
        for (int i = 0; i < n; i++) send_byte(random_follow());
        sent += n + 1;
      end else if (pick < 92) begin
        n = $urandom_range(1, 3);
        keep = $urandom_range(0, n - 1);
        send_byte(random_lead(n));
        for (int i = 0; i < keep; i++) send_byte(random_follow());
        send_byte(8'h00);
        sent += keep + 2;
      end else begin
        send_byte(8'h00);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 88;
    test_plain_bytes();
    test_invalid_leads();
    test_full_sequences();
    test_truncated_flush();
    test_random_text(40);

    send_idle_pct = 88;
    recv_idle_pct = 38;
    test_random_text(50);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(50);
    send_byte(8'h00);

    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
